// ===== sv/buddy_block_allocator_unit_defines.svh =====
// Assertion helpers shared by the allocator RTL.
`ifndef BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define BBA_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked while out of reset.
`define BBA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bba_pkg.sv =====
`default_nettype none
package bba_pkg;

  localparam int MIN_ORDER    = 3;
  localparam int HEADER_BYTES = 8;
  localparam int FIELD_W      = 12;

  localparam logic [3:0] POOL_ORDER_RST = 4'd12;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_DOUBLE = 2'd3
  } bba_status_t;

  typedef struct packed {
    logic               req_type;
    logic [FIELD_W-1:0] req_size;
    logic [FIELD_W-1:0] free_addr;
  } bba_req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] alloc_addr;
    bba_status_t        status;
  } bba_resp_t;

endpackage
`default_nettype wire

// ===== sv/buddy_block_allocator_unit.sv =====
// Buddy block allocator over one pool of 2^pool_order bytes.
// Requests arrive on the in_ channel (in_valid, in_stall, in_data); every
// accepted transfer produces exactly one result transfer on the out_ channel
// (out_valid, out_stall, out_data). An allocate returns the block offset plus
// the 8-byte header, a free returns address 0 with a status.
// Items are handled one at a time. A free steps through S_DEC, S_FREE and
// S_RESP. An allocate steps through S_DEC, S_POP, one S_SPLIT per order
// between j, the order of the list it pops, and k, the requested order,
// then S_FIN and S_RESP; each split writes one entry of the leaf memory and
// one of the link memory. A failed request goes from S_DEC to S_RESP.
// The result sits in an output register, so the next request is taken while
// a result still waits; a stalled result holds its value until taken, and a
// finished item waits for the register before the block goes idle again.
// After reset, and after every write of pool_order through the APB port,
// the block sweeps all 2^(MAX_ORDER-3) entries (512 at the default) of the
// leaf and link memories once, one entry per cycle, with in_stall high. Then
// the pool is one free block.
`default_nettype none
`include "buddy_block_allocator_unit_defines.svh"
module buddy_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_ORDER = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire bba_req_t    in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      bba_resp_t   out_data,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int OW      = (($clog2(MAX_ORDER+1)) < 5) ? 5 : $clog2(MAX_ORDER+1);
  localparam int NLISTS  = MAX_ORDER - MIN_ORDER + 1;
  localparam int LI_W    = $clog2(NLISTS);
  localparam int LEAF_W  = MAX_ORDER - MIN_ORDER;
  localparam int NLEAVES = 1 << LEAF_W;

  typedef enum logic [7:0] {
    S_CLR   = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_POP   = 8'b0000_1000,
    S_SPLIT = 8'b0001_0000,
    S_FIN   = 8'b0010_0000,
    S_FREE  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_t;

  typedef logic [OW:0]     leaf_word_t;  // free flag above the block order
  typedef logic [LEAF_W:0] link_word_t;  // link-valid flag above the next leaf

  // Control and payload registers.
  state_t              state_r, state_nxt;
  logic [3:0]          pool_order_r, pool_order_nxt;
  logic [LEAF_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [LEAF_W-1:0]   head_r [NLISTS];
  logic [LEAF_W-1:0]   head_nxt [NLISTS];
  logic [NLISTS-1:0]   ne_r, ne_nxt;
  bba_req_t            req_r, req_nxt;
  logic [OW-1:0]       k_r, k_nxt;
  logic [OW-1:0]       o_r, o_nxt;
  logic [LEAF_W-1:0]   b_r, b_nxt;
  bba_status_t         status_r, status_nxt;
  logic [FIELD_W-1:0]  addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  bba_resp_t           out_data_r, out_data_nxt;

  // Leaf memory (order and free flag per leaf) and link memory.
  leaf_word_t          leaf_mem [NLEAVES];
  link_word_t          link_mem [NLEAVES];
  logic                lm_we;
  logic [LEAF_W-1:0]   lm_waddr;
  leaf_word_t          lm_wdata;
  logic [LEAF_W-1:0]   lm_raddr;
  leaf_word_t          lm_rdata;
  logic                nl_we;
  logic [LEAF_W-1:0]   nl_waddr;
  link_word_t          nl_wdata;
  logic [LEAF_W-1:0]   nl_raddr;
  link_word_t          nl_rdata;

  logic [OW-1:0]       pool_eff;
  logic [OW-1:0]       plan_k;
  logic [LI_W-1:0]     plan_j;
  bba_status_t         plan_status;
  logic [LI_W-1:0]     head_ridx;
  logic [LEAF_W-1:0]   head_rd;
  logic [FIELD_W-1:0]  free_off;
  logic                free_outside;
  logic [LEAF_W-1:0]   free_leaf;
  logic [OW-1:0]       free_ord;
  logic [LI_W-1:0]     free_li;
  logic [OW-1:0]       split_lo;
  logic [LI_W-1:0]     split_li;
  logic [LEAF_W-1:0]   split_up;
  logic [LI_W-1:0]     pop_li;
  logic                cfg_wr;

  // Pool orders below 4 act as 4, above MAX_ORDER as MAX_ORDER.
  always_comb begin
    if (pool_order_r < 4'd4) begin
      pool_eff = OW'(4);
    end else if (OW'(pool_order_r) > OW'(MAX_ORDER)) begin
      pool_eff = OW'(MAX_ORDER);
    end else begin
      pool_eff = OW'(pool_order_r);
    end
  end

  bba_alloc_plan #(
    .MAX_ORDER (MAX_ORDER)
  ) u_plan (
    .req_size (req_r.req_size),
    .pool_eff (pool_eff),
    .nonempty (ne_r),
    .k_order  (plan_k),
    .j_idx    (plan_j),
    .status   (plan_status)
  );

  // A free names the header address; the leaf is the block offset in slots.
  assign free_off     = req_r.free_addr - FIELD_W'(HEADER_BYTES);
  assign free_outside = (free_off >> pool_eff) != '0;
  assign free_leaf    = LEAF_W'(free_off[FIELD_W-1:MIN_ORDER]);

  // Recorded order of a freed leaf is held to the legal range.
  always_comb begin
    free_ord = lm_rdata[OW-1:0];
    if (free_ord < OW'(MIN_ORDER)) free_ord = OW'(MIN_ORDER);
    if (free_ord > pool_eff) free_ord = pool_eff;
  end
  assign free_li = LI_W'(free_ord - OW'(MIN_ORDER));

  // One split: the upper half of the current block goes one order down.
  assign split_lo = o_r - OW'(1);
  assign split_li = LI_W'(split_lo - OW'(MIN_ORDER));
  assign split_up = b_r + (LEAF_W'(1) << (split_lo - OW'(MIN_ORDER)));
  assign pop_li   = LI_W'(o_r - OW'(MIN_ORDER));

  // Single read port into the list heads.
  always_comb begin
    case (state_r)
      S_DEC:   head_ridx = plan_j;
      S_SPLIT: head_ridx = split_li;
      S_FREE:  head_ridx = free_li;
      default: head_ridx = '0;
    endcase
  end
  assign head_rd = head_r[head_ridx];

  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata   = {28'd0, pool_order_r};
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    pool_order_nxt = pool_order_r;
    clr_cnt_nxt    = clr_cnt_r;
    head_nxt       = head_r;
    ne_nxt         = ne_r;
    req_nxt        = req_r;
    k_nxt          = k_r;
    o_nxt          = o_r;
    b_nxt          = b_r;
    status_nxt     = status_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    lm_we          = 1'b0;
    lm_waddr       = b_r;
    lm_wdata       = '0;
    lm_raddr       = free_leaf;
    nl_we          = 1'b0;
    nl_waddr       = b_r;
    nl_wdata       = '0;
    nl_raddr       = head_rd;

    case (state_r)
      S_CLR: begin
        // Leaf 0 holds the whole pool as one free block with no successor.
        for (int i = 0; i < NLISTS; i++) begin
          head_nxt[i] = '0;
        end
        ne_nxt   = NLISTS'(1) << (pool_eff - OW'(MIN_ORDER));
        lm_we    = 1'b1;
        lm_waddr = clr_cnt_r;
        lm_wdata = (clr_cnt_r == '0) ? {1'b1, pool_eff} : '0;
        nl_we    = 1'b1;
        nl_waddr = clr_cnt_r;
        nl_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + LEAF_W'(1);
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        addr_nxt = '0;
        if (req_r.req_type == REQ_ALLOC) begin
          if (plan_status != ST_OK) begin
            status_nxt = plan_status;
            state_nxt  = S_RESP;
          end else begin
            status_nxt = ST_OK;
            k_nxt      = plan_k;
            o_nxt      = OW'(plan_j) + OW'(MIN_ORDER);
            b_nxt      = head_rd;
            state_nxt  = S_POP;
          end
        end else begin
          if (free_outside) begin
            status_nxt = ST_RANGE;
            state_nxt  = S_RESP;
          end else begin
            b_nxt     = free_leaf;
            state_nxt = S_FREE;
          end
        end
      end
      S_POP: begin
        if (nl_rdata[LEAF_W]) begin
          head_nxt[pop_li] = nl_rdata[LEAF_W-1:0];
        end else begin
          head_nxt[pop_li] = '0;
          ne_nxt[pop_li]   = 1'b0;
        end
        state_nxt = (o_r > k_r) ? S_SPLIT : S_FIN;
      end
      S_SPLIT: begin
        lm_we    = 1'b1;
        lm_waddr = split_up;
        lm_wdata = {1'b1, split_lo};
        nl_we    = 1'b1;
        nl_waddr = split_up;
        nl_wdata = ne_r[split_li] ? {1'b1, head_rd} : '0;
        head_nxt[split_li] = split_up;
        ne_nxt[split_li]   = 1'b1;
        o_nxt = split_lo;
        if (split_lo == k_r) state_nxt = S_FIN;
      end
      S_FIN: begin
        lm_we      = 1'b1;
        lm_waddr   = b_r;
        lm_wdata   = {1'b0, k_r};
        addr_nxt   = FIELD_W'({b_r, {MIN_ORDER{1'b0}}}) + FIELD_W'(HEADER_BYTES);
        status_nxt = ST_OK;
        state_nxt  = S_RESP;
      end
      S_FREE: begin
        if (lm_rdata[OW]) begin
          status_nxt = ST_DOUBLE;
        end else begin
          // Only the free flag changes; the recorded order stays.
          status_nxt = ST_OK;
          lm_we      = 1'b1;
          lm_waddr   = b_r;
          lm_wdata   = {1'b1, lm_rdata[OW-1:0]};
          nl_we      = 1'b1;
          nl_waddr   = b_r;
          nl_wdata   = ne_r[free_li] ? {1'b1, head_rd} : '0;
          head_nxt[free_li] = b_r;
          ne_nxt[free_li]   = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{alloc_addr: addr_r, status: status_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase

    // A pool_order write rebuilds the pool.
    if (cfg_wr && (paddr[2] == 1'b0)) begin
      pool_order_nxt = pwdata[3:0];
      clr_cnt_nxt    = '0;
      state_nxt      = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      pool_order_r <= POOL_ORDER_RST;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pool_order_r <= pool_order_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    head_r     <= head_nxt;
    ne_r       <= ne_nxt;
    req_r      <= req_nxt;
    k_r        <= k_nxt;
    o_r        <= o_nxt;
    b_r        <= b_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (lm_we) leaf_mem[lm_waddr] <= lm_wdata;
    lm_rdata <= leaf_mem[lm_raddr];
  end

  always_ff @(posedge clk) begin
    if (nl_we) link_mem[nl_waddr] <= nl_wdata;
    nl_rdata <= link_mem[nl_raddr];
  end

  `BBA_ASSERT_IMPL(a_split_above_req, clk, rst_n, state_r == S_SPLIT, o_r > k_r, "split below requested order")
  `BBA_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && !in_stall && !cfg_wr, state_r == S_DEC, "accepted transfer not decoded")
  `BBA_ASSERT_NEXT(a_resp_delivers, clk, rst_n, state_r == S_RESP && !out_stall && !cfg_wr, out_valid_r, "result not loaded")

endmodule
`default_nettype wire

// ===== sv/bba_alloc_plan.sv =====
`default_nettype none
// Rounds a request up to its order and picks the smallest fitting non-empty list.
module bba_alloc_plan
  import bba_pkg::*;
#(
  parameter int MAX_ORDER = 12
) (
  input  wire logic [FIELD_W-1:0]                  req_size,
  input  wire logic [((($clog2(MAX_ORDER+1)) < 5) ? 5 : $clog2(MAX_ORDER+1))-1:0] pool_eff,
  input  wire logic [MAX_ORDER-MIN_ORDER:0]        nonempty,
  output      logic [((($clog2(MAX_ORDER+1)) < 5) ? 5 : $clog2(MAX_ORDER+1))-1:0] k_order,
  output      logic [$clog2(MAX_ORDER-MIN_ORDER+1)-1:0] j_idx,
  output      bba_status_t                         status
);

  localparam int OW     = (($clog2(MAX_ORDER+1)) < 5) ? 5 : $clog2(MAX_ORDER+1);
  localparam int NLISTS = MAX_ORDER - MIN_ORDER + 1;
  localparam int LI_W   = $clog2(NLISTS);
  localparam int NEED_W = FIELD_W + 1;

  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] need_m1;
  logic [OW-1:0]     blen;
  logic              found;

  assign need    = NEED_W'(req_size) + NEED_W'(HEADER_BYTES);
  assign need_m1 = need - NEED_W'(1);

  always_comb begin
    blen = '0;
    for (int i = 0; i < NEED_W; i++) begin
      if (need_m1[i]) blen = OW'(i + 1);
    end
    k_order = (need <= NEED_W'(HEADER_BYTES)) ? OW'(MIN_ORDER) : blen;
  end

  // Lowest qualifying list wins, so scan from the top down.
  always_comb begin
    found = 1'b0;
    j_idx = '0;
    for (int i = NLISTS - 1; i >= 0; i--) begin
      if (nonempty[i] && (OW'(i + MIN_ORDER) >= k_order) &&
          (OW'(i + MIN_ORDER) <= pool_eff)) begin
        found = 1'b1;
        j_idx = LI_W'(i);
      end
    end
  end

  always_comb begin
    if (k_order > pool_eff) begin
      status = ST_RANGE;
    end else if (!found) begin
      status = ST_EMPTY;
    end else begin
      status = ST_OK;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top
  import bba_pkg::*;
;

  // Predicts the allocator's answers and holds them until the matching result
  // transfer appears on the output channel.
  class alloc_scoreboard;
    logic [3:0] pool_reg;
    bit   [8:0] head_leaf [10];
    bit         list_full [10];
    bit   [9:0] link_of   [512];
    bit   [3:0] order_of  [512];
    bit         is_free   [512];
    bba_resp_t  expected_q [$];
    int         errors;

    function int eff_pool();
      int p;
      p = pool_reg;
      if (p < 4) p = 4;
      if (p > 12) p = 12;
      return p;
    endfunction

    function void push_leaf(int leaf, int ord);
      int li;
      li = ord - MIN_ORDER;
      link_of[leaf] = list_full[li] ? {1'b1, head_leaf[li]} : 10'd0;
      head_leaf[li] = leaf[8:0];
      list_full[li] = 1'b1;
    endfunction

    function int pop_leaf(int ord);
      int li;
      int leaf;
      li = ord - MIN_ORDER;
      leaf = head_leaf[li];
      if (link_of[leaf][9]) begin
        head_leaf[li] = link_of[leaf][8:0];
      end else begin
        list_full[li] = 1'b0;
        head_leaf[li] = '0;
      end
      return leaf;
    endfunction

    // A pool_order write (or reset) leaves the pool as one free block.
    function void set_pool(logic [3:0] value);
      pool_reg = value;
      foreach (head_leaf[i]) begin
        head_leaf[i] = '0;
        list_full[i] = 1'b0;
      end
      foreach (link_of[i]) begin
        link_of[i] = '0;
        order_of[i] = '0;
        is_free[i] = 1'b0;
      end
      order_of[0] = eff_pool();
      is_free[0] = 1'b1;
      push_leaf(0, eff_pool());
    endfunction

    function bba_resp_t note_request(bba_req_t req);
      bba_resp_t res;
      int pool, need, k, j, b, up, o, leaf;
      logic [11:0] off;
      pool = eff_pool();
      res.alloc_addr = '0;
      res.status = ST_OK;
      if (req.req_type == REQ_ALLOC) begin
        need = int'(req.req_size) + HEADER_BYTES;
        k = MIN_ORDER;
        while (k < 31 && (1 << k) < need) k++;
        if (k > pool) begin
          res.status = ST_RANGE;
        end else begin
          j = k;
          while (j <= pool && !list_full[j - MIN_ORDER]) j++;
          if (j > pool) begin
            res.status = ST_EMPTY;
          end else begin
            b = pop_leaf(j);
            // Split down: the upper half goes free, the lower half is kept.
            for (o = j; o > k; o--) begin
              up = (b + (1 << (o - 1 - MIN_ORDER))) & 511;
              order_of[up] = o - 1;
              is_free[up] = 1'b1;
              push_leaf(up, o - 1);
            end
            order_of[b] = k;
            is_free[b] = 1'b0;
            res.alloc_addr = 12'((b << MIN_ORDER) + HEADER_BYTES);
          end
        end
      end else begin
        off = req.free_addr - 12'(HEADER_BYTES);
        leaf = off >> MIN_ORDER;
        if (leaf >= (1 << (pool - MIN_ORDER))) begin
          res.status = ST_RANGE;
        end else if (is_free[leaf]) begin
          res.status = ST_DOUBLE;
        end else begin
          o = order_of[leaf];
          if (o < MIN_ORDER) o = MIN_ORDER;
          if (o > pool) o = pool;
          is_free[leaf] = 1'b1;
          push_leaf(leaf, o);
        end
      end
      expected_q.push_back(res);
      return res;
    endfunction

    function void check_result(bba_resp_t got);
      bba_resp_t exp_res;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer: addr %0d status %0d",
                                   got.alloc_addr, got.status);
        return;
      end
      exp_res = expected_q.pop_front();
      if (got.alloc_addr !== exp_res.alloc_addr || got.status !== exp_res.status) begin
        errors++;
        if (errors <= 10)
          $display("result mismatch: expected addr %0d status %0d, got addr %0d status %0d",
                   exp_res.alloc_addr, exp_res.status, got.alloc_addr, got.status);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  bba_req_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  bba_resp_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb = new;

  // Addresses handed out by successful allocates and not yet freed.
  logic [11:0] live_addrs [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  logic [3:0] pool_plan [7] = '{4'd4, 4'd12, 4'd0, 4'd15, 4'd7, 4'd9, 4'd5};

  buddy_block_allocator_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("** buddy_block_allocator_unit: FAILED **");
    $finish;
  end

  // Result side: a transfer is checked on the edge where it completes, using
  // the stall value from before that edge. A long hold-off, when requested,
  // is counted down here one cycle at a time.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Offer one request and keep it steady until it is taken. A random gap
  // may come first, depending on the sender's idle rate.
  task automatic send_request(input bba_req_t req);
    bba_resp_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    res = sb.note_request(req);
    if (req.req_type == REQ_ALLOC && res.status == ST_OK) live_addrs.push_back(res.alloc_addr);
  endtask

  task automatic send_alloc(input int size);
    bba_req_t req;
    req.req_type = REQ_ALLOC;
    req.req_size = 12'(size);
    req.free_addr = 12'($urandom);
    send_request(req);
  endtask

  task automatic send_free(input logic [11:0] addr);
    bba_req_t req;
    req.req_type = REQ_FREE;
    req.req_size = 12'($urandom);
    req.free_addr = addr;
    send_request(req);
  endtask

  // Mostly allocates of small blocks and frees of live blocks; the rest are
  // large sizes and frees of arbitrary addresses.
  task automatic send_random();
    int roll, pick;
    logic [11:0] addr;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) send_alloc($urandom_range(0, 56));
      else if (pick < 9) send_alloc($urandom_range(0, 500));
      else send_alloc($urandom_range(0, 4095));
    end else if (roll < 90 && live_addrs.size() > 0) begin
      pick = $urandom_range(0, live_addrs.size() - 1);
      addr = live_addrs[pick];
      live_addrs.delete(pick);
      send_free(addr);
    end else begin
      send_free(12'($urandom));
    end
  endtask

  // Let the block drain completely, then rewrite pool_order through a setup
  // and an access cycle.
  task automatic write_pool(input logic [3:0] value);
    in_valid <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (20) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {28'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_pool(value);
    live_addrs.delete();
  endtask

  initial begin
    sb.set_pool(POOL_ORDER_RST);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the default pool.
    send_alloc(4088);          // whole pool in one block
    send_alloc(0);             // nothing left
    send_free(12'd8);
    send_free(12'd8);          // double free
    send_alloc(4095);          // larger than the pool
    send_alloc(0);             // header-only block, split all the way down
    send_alloc(8);
    send_alloc(9);
    send_alloc(2040);
    send_free(12'd0);          // wraps to the last leaf, not a live block start
    send_free(12'd8 + 12'd3);  // misaligned free of the first block
    send_alloc(0);
    send_alloc(4088);
    send_free(12'hfff);
    send_alloc(1000);
    send_alloc(3000);
    send_free(12'd24);
    send_alloc(16);
    live_addrs.delete();

    foreach (pool_plan[ph]) begin
      write_pool(pool_plan[ph]);
      case (ph % 3)
        0: begin
          send_idle_pct = 11;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 11;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 250; n++) begin
        // The output holds off for a long stretch while requests keep coming.
        if (ph == 1 && n == 100) hold_cycles = 300;
        // The sender pauses until every outstanding result has drained.
        if (ph == 2 && n == 120) begin
          in_valid <= 1'b0;
          wait (sb.expected_q.size() == 0);
          @(posedge clk);
        end
        send_random();
      end
    end
    in_valid <= 1'b0;

    wait (sb.expected_q.size() == 0);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("** buddy_block_allocator_unit: PASSED **");
    end else begin
      $display("** buddy_block_allocator_unit: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== buddy_block_allocator_unit.f =====
+incdir+sv
sv/bba_pkg.sv
sv/bba_alloc_plan.sv
sv/buddy_block_allocator_unit.sv
tb/tb_top.sv
